// ===== hdl/xcbs_pkg.sv =====
// Shared types, codes and the CRC-16 step for the XMODEM-CRC block sender.
// No dependencies; the design files and the testbench refer to this package, the checker does not.
package xcbs_pkg;

    // Data bytes per block
    localparam int BLOCK_SIZE = 128;
    localparam int BIB_W      = $clog2(BLOCK_SIZE + 1);

    // Line characters
    localparam logic [7:0] C_SOH = 8'h01;
    localparam logic [7:0] C_EOT = 8'h04;
    localparam logic [7:0] C_ACK = 8'h06;
    localparam logic [7:0] C_NAK = 8'h15;
    localparam logic [7:0] C_PAD = 8'h1A;

    // Request kinds (carried on tuser)
    localparam logic [2:0] OP_PAYLOAD = 3'd0;
    localparam logic [2:0] OP_PAD     = 3'd1;
    localparam logic [2:0] OP_RX      = 3'd2;
    localparam logic [2:0] OP_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;

    // Transfer phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_SEND   = 4'd1;
    localparam logic [3:0] PH_BLKACK = 4'd2;
    localparam logic [3:0] PH_PAD    = 4'd3;
    localparam logic [3:0] PH_FINACK = 4'd4;
    localparam logic [3:0] PH_NAK    = 4'd5;
    localparam logic [3:0] PH_ACK    = 4'd6;
    localparam logic [3:0] PH_DONE   = 4'd7;
    localparam logic [3:0] PH_ABORT  = 4'd8;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One request's worth of output: up to four bytes
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            tx;
        logic [3:0]      phase;
    } entry_t;

    // CRC-16, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hdl/xcbs_front.sv =====
// Front end: accepts requests, runs the XMODEM phase machine, block count and CRC,
// and emits one queue entry per request. Depends on xcbs_pkg.
module xcbs_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic [7:0]         data,
    input  logic               q_full,
    output logic               push,
    output xcbs_pkg::entry_t   push_entry
);

    logic [3:0]                    phase_reg, phase_next;
    logic [7:0]                    pn_reg, pn_next;
    logic [xcbs_pkg::BIB_W-1:0]    bib_reg, bib_next;
    logic [15:0]                   crc_reg, crc_next;

    logic [7:0]                    data_byte;
    logic [15:0]                   crc_upd;
    logic [xcbs_pkg::BIB_W-1:0]    bib_inc;
    logic                          full;
    logic                          take_data;
    logic                          got;
    logic [7:0]                    pn_inc;
    logic [3:0][7:0]               bytes;
    logic [2:0]                    nbytes;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    // Data byte of this request and its effect on CRC and count
    assign data_byte = (op == xcbs_pkg::OP_PAD) ? xcbs_pkg::C_PAD : data;
    assign crc_upd   = xcbs_pkg::crc_byte(crc_reg, data_byte);
    assign bib_inc   = bib_reg + 1'b1;
    assign full      = (bib_inc >= xcbs_pkg::BIB_W'(xcbs_pkg::BLOCK_SIZE));
    assign got       = (op == xcbs_pkg::OP_RX);
    assign pn_inc    = pn_reg + 8'd1;

    always_comb
    begin
        take_data = 1'b0;
        if (op == xcbs_pkg::OP_PAYLOAD)
        begin
            take_data = (phase_reg == xcbs_pkg::PH_IDLE) || (phase_reg == xcbs_pkg::PH_SEND);
        end
        else if (op == xcbs_pkg::OP_PAD)
        begin
            take_data = (phase_reg == xcbs_pkg::PH_IDLE) || (phase_reg == xcbs_pkg::PH_SEND)
                     || (phase_reg == xcbs_pkg::PH_PAD);
        end
    end

    // Next state and bytes to send
    always_comb
    begin
        phase_next = phase_reg;
        pn_next    = pn_reg;
        bib_next   = bib_reg;
        crc_next   = crc_reg;
        bytes      = '0;
        nbytes     = 3'd0;
        unique case (op)
            xcbs_pkg::OP_PAYLOAD, xcbs_pkg::OP_PAD:
            begin
                if (take_data)
                begin
                    crc_next = crc_upd;
                    bib_next = full ? '0 : bib_inc;
                    if (phase_reg == xcbs_pkg::PH_IDLE)
                    begin
                        // Open the first block: header, then the data byte
                        bytes[0] = xcbs_pkg::C_SOH;
                        bytes[1] = pn_reg;
                        bytes[2] = ~pn_reg;
                        bytes[3] = data_byte;
                        nbytes   = 3'd4;
                        phase_next = (op == xcbs_pkg::OP_PAYLOAD) ? xcbs_pkg::PH_SEND
                                                                  : xcbs_pkg::PH_PAD;
                    end
                    else
                    begin
                        bytes[0] = data_byte;
                        if (full)
                        begin
                            // Close the block with the CRC, high byte first
                            bytes[1]   = crc_upd[15:8];
                            bytes[2]   = crc_upd[7:0];
                            nbytes     = 3'd3;
                            phase_next = (op == xcbs_pkg::OP_PAYLOAD) ? xcbs_pkg::PH_BLKACK
                                                                      : xcbs_pkg::PH_FINACK;
                        end
                        else
                        begin
                            nbytes     = 3'd1;
                            phase_next = (op == xcbs_pkg::OP_PAYLOAD) ? xcbs_pkg::PH_SEND
                                                                      : xcbs_pkg::PH_PAD;
                        end
                    end
                end
            end
            xcbs_pkg::OP_RX, xcbs_pkg::OP_TIMEOUT:
            begin
                unique case (phase_reg)
                    xcbs_pkg::PH_BLKACK:
                    begin
                        if (got && data == xcbs_pkg::C_ACK)
                        begin
                            // Next block: new header, fresh CRC
                            pn_next    = pn_inc;
                            crc_next   = '0;
                            bytes[0]   = xcbs_pkg::C_SOH;
                            bytes[1]   = pn_inc;
                            bytes[2]   = ~pn_inc;
                            nbytes     = 3'd3;
                            phase_next = xcbs_pkg::PH_SEND;
                        end
                        else
                        begin
                            phase_next = xcbs_pkg::PH_ABORT;
                        end
                    end
                    xcbs_pkg::PH_FINACK:
                    begin
                        if (got && data == xcbs_pkg::C_ACK)
                        begin
                            bytes[0]   = xcbs_pkg::C_EOT;
                            nbytes     = 3'd1;
                            phase_next = xcbs_pkg::PH_NAK;
                        end
                        else
                        begin
                            phase_next = xcbs_pkg::PH_ABORT;
                        end
                    end
                    xcbs_pkg::PH_NAK:
                    begin
                        if (got && data == xcbs_pkg::C_NAK)
                        begin
                            bytes[0]   = xcbs_pkg::C_EOT;
                            nbytes     = 3'd1;
                            phase_next = xcbs_pkg::PH_ACK;
                        end
                        else
                        begin
                            phase_next = xcbs_pkg::PH_ABORT;
                        end
                    end
                    xcbs_pkg::PH_ACK:
                    begin
                        phase_next = (got && data == xcbs_pkg::C_ACK) ? xcbs_pkg::PH_DONE
                                                                      : xcbs_pkg::PH_ABORT;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            xcbs_pkg::OP_RESTART:
            begin
                phase_next = xcbs_pkg::PH_IDLE;
                pn_next    = 8'd1;
                bib_next   = '0;
                crc_next   = '0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Pack the queue entry; a request that sends nothing gives one status result
    always_comb
    begin
        push_entry.bytes = bytes;
        push_entry.phase = phase_next;
        if (nbytes == 3'd0)
        begin
            push_entry.tx       = 1'b0;
            push_entry.last_idx = 2'd0;
        end
        else
        begin
            push_entry.tx       = 1'b1;
            push_entry.last_idx = 2'(nbytes - 3'd1);
        end
    end

    // Advance state on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= xcbs_pkg::PH_IDLE;
            pn_reg    <= 8'd1;
            bib_reg   <= '0;
            crc_reg   <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            pn_reg    <= pn_next;
            bib_reg   <= bib_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

// ===== hdl/xcbs_fifo.sv =====
// Short queue of output entries between the front and back ends.
// Depends on xcbs_pkg for the entry type and depth.
module xcbs_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  xcbs_pkg::entry_t   push_entry,
    input  logic               pop,
    output xcbs_pkg::entry_t   head,
    output logic               empty,
    output logic               full
);

    xcbs_pkg::entry_t                mem [xcbs_pkg::QDEPTH];
    logic [xcbs_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [xcbs_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [xcbs_pkg::QCNT_W-1:0]     cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == xcbs_pkg::QCNT_W'(xcbs_pkg::QDEPTH));
    assign head  = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/xcbs_back.sv =====
// Back end: takes queue entries and serializes their bytes onto the output stream
// from a registered output stage. Depends on xcbs_pkg.
module xcbs_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  xcbs_pkg::entry_t   head,
    input  logic               q_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               out_tx,
    output logic               out_last,
    output logic [3:0]         out_phase
);

    xcbs_pkg::entry_t  cur_reg;
    logic [1:0]        idx_reg;
    logic              valid_reg;
    logic              take;
    logic              free;

    assign out_valid = valid_reg;
    assign out_byte  = cur_reg.bytes[idx_reg];
    assign out_tx    = cur_reg.tx;
    assign out_last  = (idx_reg == cur_reg.last_idx);
    assign out_phase = cur_reg.phase;

    assign take = valid_reg && out_ready;
    // Stage frees up when empty or when its last result goes out
    assign free = !valid_reg || (take && out_last);
    assign pop  = free && !q_empty;

    // Load the next entry, or step through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (free)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Hold the entry being sent
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

endmodule

// ===== hdl/xmodem_crc_block_sender.sv =====
// XMODEM-CRC block sender. Each request on the input stream (tuser = kind: payload
// byte, pad step, receiver byte, receiver timeout, restart) gives one to four
// results on the output stream: bytes to transmit with tuser = 1, or one
// status-only result with tuser = 0; tlast marks the last result of a request and
// every result carries the phase after that request. The front end takes one
// request per cycle while the four-entry queue has room; the back end sends one
// result per cycle while the output is not stalled. A request makes one result for
// plain data, three at a block end or on a block's ACK, four for the first byte;
// the output stage is the limit on sustained rate. Blocks hold 128 data bytes;
// CRC-16 (0x1021, start 0) is computed one byte per cycle in the front end while
// the queue has room.
// Depends on xcbs_pkg, xcbs_front, xcbs_fifo, xcbs_back.
module xmodem_crc_block_sender
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data
    input  logic [2:0]   s_axis_tuser,   // [2:0] op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,   // [7:0] tx_byte, [11:8] phase, [15:12] zero
    output logic         m_axis_tuser,   // [0] tx_valid
    output logic         m_axis_tlast
);

    xcbs_pkg::entry_t  push_entry;
    xcbs_pkg::entry_t  head;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic [7:0]        out_byte;
    logic [3:0]        out_phase;

    xcbs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .op         (s_axis_tuser),
        .data       (s_axis_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    xcbs_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    xcbs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (out_byte),
        .out_tx     (m_axis_tuser),
        .out_last   (m_axis_tlast),
        .out_phase  (out_phase)
    );

    assign m_axis_tdata = {4'b0000, out_phase, out_byte};

endmodule

// ===== hdl/xcbs_checker.sv =====
// Port-level checks for the XMODEM-CRC block sender, bound to the top level.
// Depends on xmodem_crc_block_sender's port list only.
module xcbs_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    input  logic [2:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [15:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         m_axis_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A status-only result is alone and carries no byte
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
        else $error("status result malformed");

    // Phase stays within its codes and padding is zero
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[11:8] <= 4'd8 && m_axis_tdata[15:12] == 4'd0)
        else $error("phase field out of range");

    // Within a run of results the phase does not change
    a_phase_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
            |=> m_axis_tvalid && $stable(m_axis_tdata[11:8]) && m_axis_tuser)
        else $error("phase changed inside a run");

endmodule

bind xmodem_crc_block_sender xcbs_checker u_checker (.*);

// ===== bench/tb_xmodem_crc_block_sender.sv =====
// Testbench for the XMODEM-CRC block sender: drives requests on the input stream
// and checks every output result against a built-in prediction of the sender.
// Depends on xcbs_pkg and xmodem_crc_block_sender.
`timescale 1ns / 100ps

module tb_xmodem_crc_block_sender;

    localparam int         MAX_RESULTS    = 4;
    localparam int         ITEM_TARGET    = 250;
    localparam int         PACE_SPAN      = 64;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         REPORT_LIMIT   = 10;
    localparam longint     WATCHDOG_NS    = 64'd10_000_000;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // One expected output beat
    typedef struct {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       last;
        logic [3:0] phase;
    } tx_result_t;

    // Sender state mirror plus the queue of results still to come
    class crc_sender_scoreboard;
        logic [3:0]  phase;
        logic [7:0]  pkt_no;
        int          fill;
        logic [15:0] crc;
        logic [7:0]  line_bytes[$];
        tx_result_t  awaited[$];
        int          requests;
        int          results;
        int          errors;
        int          blocks_acked;
        int          transfers_done;
        int          transfers_aborted;

        function new();
            requests          = 0;
            results           = 0;
            errors            = 0;
            blocks_acked      = 0;
            transfers_done    = 0;
            transfers_aborted = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase  = xcbs_pkg::PH_IDLE;
            pkt_no = 8'd1;
            fill   = 0;
            crc    = 16'h0000;
        endfunction

        // Feed one byte through the CRC register, top bit first
        function logic [15:0] crc_shift(logic [15:0] c, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[15] ^ b[i];
                c  = {c[14:0], 1'b0};
                if (fb)
                    c = c ^ xcbs_pkg::CRC_POLY;
            end
            return c;
        endfunction

        function void put_header();
            line_bytes.push_back(xcbs_pkg::C_SOH);
            line_bytes.push_back(pkt_no);
            line_bytes.push_back(~pkt_no);
        endfunction

        // Append a data byte; close the block with its CRC once it is full
        function void put_data(logic [7:0] b, logic [3:0] full_phase);
            crc = crc_shift(crc, b);
            line_bytes.push_back(b);
            fill++;
            if (fill >= xcbs_pkg::BLOCK_SIZE)
            begin
                fill = 0;
                line_bytes.push_back(crc[15:8]);
                line_bytes.push_back(crc[7:0]);
                phase = full_phase;
            end
        endfunction

        function void abort_transfer();
            phase = xcbs_pkg::PH_ABORT;
            transfers_aborted++;
        endfunction

        // Advance a waiting phase on a receiver byte or a timeout
        function void take_reply(bit got, logic [7:0] b);
            case (phase)
                xcbs_pkg::PH_BLKACK:
                    if (got && b == xcbs_pkg::C_ACK)
                    begin
                        pkt_no = pkt_no + 8'd1;
                        crc    = 16'h0000;
                        put_header();
                        phase  = xcbs_pkg::PH_SEND;
                        blocks_acked++;
                    end
                    else
                        abort_transfer();
                xcbs_pkg::PH_FINACK:
                    if (got && b == xcbs_pkg::C_ACK)
                    begin
                        line_bytes.push_back(xcbs_pkg::C_EOT);
                        phase = xcbs_pkg::PH_NAK;
                    end
                    else
                        abort_transfer();
                xcbs_pkg::PH_NAK:
                    if (got && b == xcbs_pkg::C_NAK)
                    begin
                        line_bytes.push_back(xcbs_pkg::C_EOT);
                        phase = xcbs_pkg::PH_ACK;
                    end
                    else
                        abort_transfer();
                xcbs_pkg::PH_ACK:
                    if (got && b == xcbs_pkg::C_ACK)
                    begin
                        phase = xcbs_pkg::PH_DONE;
                        transfers_done++;
                    end
                    else
                        abort_transfer();
                default:
                    ;
            endcase
        endfunction

        function bit awaiting_reply();
            return phase == xcbs_pkg::PH_BLKACK || phase == xcbs_pkg::PH_FINACK
                || phase == xcbs_pkg::PH_NAK || phase == xcbs_pkg::PH_ACK;
        endfunction

        // Work out the results of one accepted request
        function void note_request(logic [2:0] op, logic [7:0] d);
            int         n;
            tx_result_t r;
            line_bytes.delete();
            requests++;
            case (op)
                xcbs_pkg::OP_PAYLOAD:
                begin
                    if (phase == xcbs_pkg::PH_IDLE)
                    begin
                        put_header();
                        phase = xcbs_pkg::PH_SEND;
                    end
                    if (phase == xcbs_pkg::PH_SEND)
                        put_data(d, xcbs_pkg::PH_BLKACK);
                end
                xcbs_pkg::OP_PAD:
                begin
                    if (phase == xcbs_pkg::PH_IDLE)
                        put_header();
                    if (phase == xcbs_pkg::PH_IDLE || phase == xcbs_pkg::PH_SEND
                        || phase == xcbs_pkg::PH_PAD)
                    begin
                        phase = xcbs_pkg::PH_PAD;
                        put_data(xcbs_pkg::C_PAD, xcbs_pkg::PH_FINACK);
                    end
                end
                xcbs_pkg::OP_RX:
                    take_reply(1'b1, d);
                xcbs_pkg::OP_TIMEOUT:
                    take_reply(1'b0, 8'h00);
                xcbs_pkg::OP_RESTART:
                    clear_state();
                default:
                    ;
            endcase

            if (line_bytes.size() == 0)
            begin
                r.tx_byte  = 8'h00;
                r.tx_valid = 1'b0;
                r.last     = 1'b1;
                r.phase    = phase;
                awaited.push_back(r);
            end
            else
            begin
                n = (line_bytes.size() > MAX_RESULTS) ? MAX_RESULTS : line_bytes.size();
                for (int k = 0; k < n; k++)
                begin
                    r.tx_byte  = line_bytes[k];
                    r.tx_valid = 1'b1;
                    r.last     = (k == n - 1);
                    r.phase    = phase;
                    awaited.push_back(r);
                end
            end
        endfunction

        function void flag(string what, logic [15:0] exp_v, logic [15:0] got_v);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: mismatch on result %0d, %s: expected %0h, got %0h",
                         $time, results, what, exp_v, got_v);
        endfunction

        // Compare one output beat with the oldest expectation
        function void check_result(logic [15:0] tdata, logic tuser, logic tlast);
            tx_result_t e;
            results++;
            if (awaited.size() == 0)
            begin
                flag("result with nothing pending, tdata", 16'h0000, tdata);
                return;
            end
            e = awaited.pop_front();
            if (tdata[7:0] !== e.tx_byte)
                flag("tx_byte", 16'(e.tx_byte), 16'(tdata[7:0]));
            if (tdata[11:8] !== e.phase)
                flag("phase", 16'(e.phase), 16'(tdata[11:8]));
            if (tdata[15:12] !== 4'h0)
                flag("tdata fill bits", 16'h0000, 16'(tdata[15:12]));
            if (tuser !== e.tx_valid)
                flag("tx_valid", 16'(e.tx_valid), 16'(tuser));
            if (tlast !== e.last)
                flag("last", 16'(e.last), 16'(tlast));
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic [2:0]  s_axis_tuser  = xcbs_pkg::OP_PAYLOAD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    crc_sender_scoreboard sb;

    xmodem_crc_block_sender DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the output stream at random
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    task automatic set_pacing(int mode);
        case (mode)
            0:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            1:
            begin
                src_idle_pct  = 45;
                snk_stall_pct = 0;
            end
            2:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 45;
            end
            default:
            begin
                src_idle_pct  = 21;
                snk_stall_pct = 21;
            end
        endcase
    endtask

    // Offer one request, with a random gap ahead of it, and hold it until taken
    task automatic send_request(logic [2:0] op, logic [7:0] d);
        set_pacing((sb.requests / PACE_SPAN) % 4);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(op, d);
    endtask

    // Send a request that the current phase leaves without effect
    task automatic send_ignored();
        logic [2:0] op;
        if (sb.awaiting_reply())
        begin
            case ($urandom_range(0, 2))
                0:       op = xcbs_pkg::OP_PAYLOAD;
                1:       op = xcbs_pkg::OP_PAD;
                default: op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            endcase
        end
        else if (sb.phase == xcbs_pkg::PH_DONE || sb.phase == xcbs_pkg::PH_ABORT)
        begin
            case ($urandom_range(0, 4))
                0:       op = xcbs_pkg::OP_PAYLOAD;
                1:       op = xcbs_pkg::OP_PAD;
                2:       op = xcbs_pkg::OP_RX;
                3:       op = xcbs_pkg::OP_TIMEOUT;
                default: op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       op = xcbs_pkg::OP_RX;
                1:       op = xcbs_pkg::OP_TIMEOUT;
                default: op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            endcase
        end
        send_request(op, 8'($urandom_range(0, 255)));
    endtask

    // Answer a waiting phase: mostly the right reply, sometimes a wrong byte, a timeout or an ignored request
    task automatic answer_wait();
        logic [7:0] good;
        logic [7:0] b;
        int         roll;
        good = (sb.phase == xcbs_pkg::PH_NAK) ? xcbs_pkg::C_NAK : xcbs_pkg::C_ACK;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            send_ignored();
        else if (roll < 88)
            send_request(xcbs_pkg::OP_RX, good);
        else if (roll < 95)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == good)
                b = ~good;
            send_request(xcbs_pkg::OP_RX, b);
        end
        else
            send_request(xcbs_pkg::OP_TIMEOUT, 8'($urandom_range(0, 255)));
    endtask

    // One transfer from restart to done or abort, with the given payload and noise
    task automatic run_transfer(int payload_len);
        int sent;
        send_request(xcbs_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
        sent = 0;
        while (sb.phase != xcbs_pkg::PH_DONE && sb.phase != xcbs_pkg::PH_ABORT)
        begin
            if (sb.awaiting_reply())
                answer_wait();
            else if ($urandom_range(0, 24) == 0)
                send_ignored();
            else if (sent < payload_len)
            begin
                send_request(xcbs_pkg::OP_PAYLOAD, 8'($urandom_range(0, 255)));
                sent++;
            end
            else
                send_request(xcbs_pkg::OP_PAD, 8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 3))
            send_ignored();
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unused codes, stray replies, start by payload and by pad, ignored requests
        send_request(xcbs_pkg::OP_RESTART, 8'h00);
        send_request(OP_SPARE_FIRST, 8'hFF);
        send_request(OP_SPARE_MID, 8'h00);
        send_request(OP_SPARE_LAST, 8'hFF);
        send_request(xcbs_pkg::OP_RX, xcbs_pkg::C_ACK);
        send_request(xcbs_pkg::OP_TIMEOUT, 8'h00);
        send_request(xcbs_pkg::OP_PAYLOAD, 8'h00);
        send_request(xcbs_pkg::OP_PAYLOAD, 8'hFF);
        send_request(xcbs_pkg::OP_PAYLOAD, 8'h80);
        send_request(xcbs_pkg::OP_PAYLOAD, 8'h01);
        send_request(xcbs_pkg::OP_RX, 8'hFF);
        send_request(xcbs_pkg::OP_TIMEOUT, 8'hFF);
        send_request(xcbs_pkg::OP_PAD, 8'h5A);
        send_request(xcbs_pkg::OP_PAYLOAD, 8'h33);
        send_request(xcbs_pkg::OP_RX, xcbs_pkg::C_NAK);
        send_request(xcbs_pkg::OP_RESTART, 8'hFF);
        send_request(xcbs_pkg::OP_PAD, 8'h00);
        send_request(xcbs_pkg::OP_PAD, 8'hFF);
        send_request(xcbs_pkg::OP_RESTART, 8'h00);

        // Two-block transfer: a full payload block, then a partial or an all-pad block
        if ($urandom_range(0, 3) == 0)
            run_transfer(xcbs_pkg::BLOCK_SIZE);
        else
            run_transfer(xcbs_pkg::BLOCK_SIZE + $urandom_range(1, xcbs_pkg::BLOCK_SIZE - 1));

        // Top up with one-block transfers when the first one ended early
        while (sb.requests < ITEM_TARGET - xcbs_pkg::BLOCK_SIZE / 2)
            run_transfer($urandom_range(1, xcbs_pkg::BLOCK_SIZE - 1));
        s_axis_tvalid <= 1'b0;

        // Drain what is still owed, then watch for stray results
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests and checked %0d results; %0d blocks acknowledged mid-transfer.",
                 sb.requests, sb.results, sb.blocks_acked);
        $display("Transfers closed by the EOT exchange: %0d, aborted: %0d, mismatches: %0d.",
                 sb.transfers_done, sb.transfers_aborted, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_xmodem_crc_block_sender OK");
        else
            $display("tb_xmodem_crc_block_sender NOT OK");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(WATCHDOG_NS);
        $display("Watchdog expired with %0d results pending.", sb.pending());
        $display("tb_xmodem_crc_block_sender NOT OK");
        $finish;
    end

endmodule
